### src/kci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_pkg: shared types and constants of the keyed curve interpolator
// Action and status codes, arithmetic widths, the controller/datapath command
// and status structures and the saturation and rounding helpers.
// ----------------------------------------------------------------------------
package kci_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic signed [31:0] RANGE_HI_RST = 32'sd10 <<< FRAC_BITS;
    localparam logic signed [31:0] Y_EMPTY_LO   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Y_EMPTY_HI   = 32'sh8000_0000;

    // Operand width of the shared multiplier and divisor width of the divider.
    localparam int OPW = 33;
    localparam int PW  = 2 * OPW;
    localparam int T_SHIFT   = 30;
    localparam int RND_SHIFT = 16;
    localparam logic signed [16:0] RND_HALF = 17'sd32768;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_INSERT  = 2'd1;
    localparam logic [1:0] ACT_EVAL    = 2'd2;
    localparam logic [1:0] ACT_RESCALE = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_SPAN = 2'd2;

    typedef enum logic [1:0] {MUL_RS, MUL_Y, MUL_S, MUL_RND} t_mul_op;
    typedef enum logic {DIV_RS, DIV_T} t_div_op;

    typedef struct packed {
        logic       capture;
        logic       do_clear;
        logic       status_set;
        logic [1:0] status_code;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_dec;
        logic       idx_load_cnt;
        logic       pos_save;
        logic       rd_prev;
        logic       wr_shift;
        logic       wr_new;
        logic       wr_rescale;
        logic       cnt_inc;
        logic       range_commit;
        logic       y_init;
        logic       y_acc;
        logic       prev_save;
        logic       cur_save;
        logic       sel_prev;
        logic       sel_cur;
        logic       mul_start;
        t_mul_op    mul_op;
        logic       div_start;
        t_div_op    div_op;
        logic       t_save;
        logic       y_save;
        logic       s_save;
        logic       value_save;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       cnt_zero;
        logic       full;
        logic       span_zero;
        logic       idx_at_cnt;
        logic       idx_at_pos;
        logic       idx_zero;
        logic       x_le_key;
        logic       x_le_smp;
        logic       mul_done;
        logic       div_done;
        logic       out_busy;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = PW'(Y_EMPTY_LO);
        lo = PW'(Y_EMPTY_HI);
        if (v > hi) return Y_EMPTY_LO;
        if (v < lo) return Y_EMPTY_HI;
        return v[31:0];
    endfunction

    // Arithmetic right shift that truncates toward zero.
    function automatic logic signed [PW-1:0] shr_tz(input logic signed [PW-1:0] p,
                                                     input int sh);
        logic signed [PW-1:0] bias;
        bias = p[PW-1] ? ((PW'(1) <<< sh) - PW'(1)) : '0;
        return (p + bias) >>> sh;
    endfunction

endpackage

### src/kci_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_if: request and result channels of the keyed curve interpolator
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
interface kci_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_spread;
    logic signed [31:0] sample_pos;
    logic [15:0]        random_unit;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    modport source(output valid, action, key_x, key_y, key_spread, sample_pos,
                   random_unit, range_min, range_max, input ready);
    modport sink(input valid, action, key_x, key_y, key_spread, sample_pos,
                 random_unit, range_min, range_max, output ready);
endinterface

interface kci_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    logic signed [31:0] out_y_min;
    logic signed [31:0] out_y_max;
    logic [5:0]         keys_held;
    logic [1:0]         status;
    modport source(output valid, sample_value, out_y_min, out_y_max, keys_held, status,
                   input ready);
    modport sink(input valid, sample_value, out_y_min, out_y_max, keys_held, status,
                 output ready);
endinterface

### src/kci_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_mul: sequential signed multiplier
// Shift-and-add on operand magnitudes, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module kci_mul import kci_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [OPW-1:0] i_a,
    input  logic signed [OPW-1:0] i_b,
    output logic                  o_done,
    output logic signed [PW-1:0]  o_prod
);
    localparam int CNW = $clog2(OPW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [PW-1:0]  r_mcand;
    logic [OPW-1:0] r_mplier;
    logic [PW-1:0]  r_acc;
    logic           r_neg;
    logic [OPW-1:0] a_abs;
    logic [OPW-1:0] b_abs;

    assign a_abs = i_a[OPW-1] ? OPW'(-i_a) : OPW'(i_a);
    assign b_abs = i_b[OPW-1] ? OPW'(-i_b) : OPW'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(OPW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= PW'(a_abs);
            r_mplier <= b_abs;
            r_acc    <= '0;
            r_neg    <= i_a[OPW-1] ^ i_b[OPW-1];
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_acc) : $signed(r_acc);

endmodule

### src/kci_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_div: sequential signed divider
// Restoring division on magnitudes, one quotient bit per cycle; the quotient
// truncates toward zero.
// ----------------------------------------------------------------------------
module kci_div import kci_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [PW-1:0]  i_num,
    input  logic signed [OPW-1:0] i_den,
    output logic                  o_done,
    output logic signed [PW-1:0]  o_quo
);
    localparam int CNW = $clog2(PW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [PW-1:0]  r_num;
    logic [OPW-1:0] r_den;
    logic [OPW-1:0] r_rem;
    logic           r_neg;
    logic [OPW:0]   trial;
    logic           ge;
    logic [OPW:0]   diff;

    assign trial = {r_rem, r_num[PW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(PW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num[PW-1] ? PW'(-i_num) : PW'(i_num);
            r_den <= i_den[OPW-1] ? OPW'(-i_den) : OPW'(i_den);
            r_rem <= '0;
            r_neg <= i_num[PW-1] ^ i_den[OPW-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[OPW-1:0] : trial[OPW-1:0];
            r_num <= {r_num[PW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_num) : $signed(r_num);

endmodule

### src/kci_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_dp: datapath of the keyed curve interpolator
// Key stores, request and table registers, the shared multiplier and divider
// and the result register.
// ----------------------------------------------------------------------------
module kci_dp import kci_pkg::*; #(
    parameter int MAX_KEYS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_key_x,
    input  logic signed [31:0] i_key_y,
    input  logic signed [31:0] i_key_spread,
    input  logic signed [31:0] i_sample_pos,
    input  logic [15:0]        i_random_unit,
    input  logic signed [31:0] i_range_min,
    input  logic signed [31:0] i_range_max,
    input  logic               i_out_ready,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic signed [31:0] o_sample_value,
    output logic signed [31:0] o_out_y_min,
    output logic signed [31:0] o_out_y_max,
    output logic [5:0]         o_keys_held,
    output logic [1:0]         o_status
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [1:0]         r_action;
    logic signed [31:0] r_kx, r_ky, r_ks, r_smp, r_rmin, r_rmax;
    logic [15:0]        r_ru;
    logic [CW-1:0]      r_count, r_idx, r_pos;
    logic signed [31:0] r_range_lo, r_range_hi, r_y_lo, r_y_hi;
    logic [1:0]         r_status;
    logic signed [31:0] r_value;
    logic signed [31:0] r_mem_x [MAX_KEYS];
    logic signed [31:0] r_mem_y [MAX_KEYS];
    logic signed [31:0] r_mem_s [MAX_KEYS];
    logic signed [31:0] r_rx, r_ry, r_rs;
    logic signed [31:0] r_x0, r_y0, r_s0, r_x1, r_y1, r_s1, r_yv, r_sv;
    logic [T_SHIFT-1:0] r_t;
    logic               r_out_valid;
    logic signed [31:0] r_out_value, r_out_ylo, r_out_yhi;
    logic [5:0]         r_out_cnt;
    logic [1:0]         r_out_status;

    logic [CW-1:0]        idx_m1;
    logic [AW-1:0]        rd_addr;
    logic                 we_x, we_ys;
    logic signed [31:0]   wd_x, wd_y, wd_s;
    logic signed [OPW-1:0] old_span, new_span, off, gap, dy, ds;
    logic signed [16:0]   ru_c;
    logic signed [OPW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_prod, div_num, div_quo;
    logic signed [OPW-1:0] div_den;
    logic                 mul_done, div_done;
    logic signed [31:0]   y_lerp, s_lerp, value;

    assign old_span = OPW'(r_range_hi) - OPW'(r_range_lo);
    assign new_span = OPW'(r_rmax) - OPW'(r_rmin);
    assign off      = OPW'(r_smp) - OPW'(r_x0);
    assign gap      = OPW'(r_x1) - OPW'(r_x0);
    assign dy       = OPW'(r_y1) - OPW'(r_y0);
    assign ds       = OPW'(r_s1) - OPW'(r_s0);
    assign ru_c     = $signed({1'b0, r_ru}) - RND_HALF;

    assign idx_m1  = r_idx - CW'(1);
    assign rd_addr = i_cmd.rd_prev ? idx_m1[AW-1:0] : r_idx[AW-1:0];

    assign we_x  = i_cmd.wr_shift | i_cmd.wr_new | i_cmd.wr_rescale;
    assign we_ys = i_cmd.wr_shift | i_cmd.wr_new;
    always_comb begin
        if (i_cmd.wr_new) begin
            wd_x = r_kx;
            wd_y = r_ky;
            wd_s = r_ks;
        end else if (i_cmd.wr_rescale) begin
            wd_x = sat32(div_quo);
            wd_y = r_ry;
            wd_s = r_rs;
        end else begin
            wd_x = r_rx;
            wd_y = r_ry;
            wd_s = r_rs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_x) begin
            r_mem_x[r_idx[AW-1:0]] <= wd_x;
        end
        if (we_ys) begin
            r_mem_y[r_idx[AW-1:0]] <= wd_y;
            r_mem_s[r_idx[AW-1:0]] <= wd_s;
        end
        r_rx <= r_mem_x[rd_addr];
        r_ry <= r_mem_y[rd_addr];
        r_rs <= r_mem_s[rd_addr];
    end

    always_comb begin
        unique case (i_cmd.mul_op)
            MUL_RS: begin
                mul_a = OPW'(r_rx);
                mul_b = new_span;
            end
            MUL_Y: begin
                mul_a = dy;
                mul_b = $signed({{(OPW-T_SHIFT){1'b0}}, r_t});
            end
            MUL_S: begin
                mul_a = ds;
                mul_b = $signed({{(OPW-T_SHIFT){1'b0}}, r_t});
            end
            default: begin
                mul_a = OPW'(ru_c);
                mul_b = OPW'(r_sv);
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.div_op)
            DIV_RS: begin
                div_num = mul_prod;
                div_den = old_span;
            end
            default: begin
                div_num = PW'(off) <<< T_SHIFT;
                div_den = gap;
            end
        endcase
    end

    kci_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    kci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign y_lerp = sat32(PW'(r_y0) + shr_tz(mul_prod, T_SHIFT));
    assign s_lerp = sat32(PW'(r_s0) + shr_tz(mul_prod, T_SHIFT));
    assign value  = sat32(PW'(r_yv) + shr_tz(mul_prod, RND_SHIFT));

    // Request capture and evaluation working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_kx     <= i_key_x;
            r_ky     <= i_key_y;
            r_ks     <= i_key_spread;
            r_smp    <= i_sample_pos;
            r_ru     <= i_random_unit;
            r_rmin   <= i_range_min;
            r_rmax   <= i_range_max;
            r_value  <= '0;
            r_status <= STAT_OK;
        end else begin
            if (i_cmd.status_set) r_status <= i_cmd.status_code;
            if (i_cmd.value_save) r_value  <= value;
        end
        if (i_cmd.pos_save) r_pos <= r_idx;
        if (i_cmd.prev_save) begin
            r_x0 <= r_rx;
            r_y0 <= r_ry;
            r_s0 <= r_rs;
        end
        if (i_cmd.cur_save) begin
            r_x1 <= r_rx;
            r_y1 <= r_ry;
            r_s1 <= r_rs;
        end
        if (i_cmd.t_save) r_t <= div_quo[T_SHIFT-1:0];
        if (i_cmd.sel_prev) begin
            r_yv <= r_y0;
            r_sv <= r_s0;
        end else if (i_cmd.sel_cur) begin
            r_yv <= r_ry;
            r_sv <= r_rs;
        end else begin
            if (i_cmd.y_save) r_yv <= y_lerp;
            if (i_cmd.s_save) r_sv <= s_lerp;
        end
    end

    // Table state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_idx      <= '0;
            r_range_lo <= '0;
            r_range_hi <= RANGE_HI_RST;
            r_y_lo     <= Y_EMPTY_LO;
            r_y_hi     <= Y_EMPTY_HI;
        end else begin
            if (i_cmd.do_clear) begin
                r_count    <= '0;
                r_range_lo <= '0;
                r_range_hi <= r_rmax;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.range_commit) begin
                r_range_lo <= r_rmin;
                r_range_hi <= r_rmax;
            end
            if (i_cmd.do_clear || i_cmd.y_init) begin
                r_y_lo <= Y_EMPTY_LO;
                r_y_hi <= Y_EMPTY_HI;
            end else if (i_cmd.y_acc) begin
                if (r_ry < r_y_lo) r_y_lo <= r_ry;
                if (r_ry > r_y_hi) r_y_hi <= r_ry;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_cmd.idx_dec) begin
                r_idx <= idx_m1;
            end else if (i_cmd.idx_load_cnt) begin
                r_idx <= r_count;
            end
        end
    end

    // Result register: a finished result waits here while the next request runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= r_value;
            r_out_ylo    <= r_y_lo;
            r_out_yhi    <= r_y_hi;
            r_out_cnt    <= 6'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_stat.action     = r_action;
    assign o_stat.cnt_zero   = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(MAX_KEYS));
    assign o_stat.span_zero  = (old_span == '0);
    assign o_stat.idx_at_cnt = (r_idx == r_count);
    assign o_stat.idx_at_pos = (r_idx == r_pos);
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.x_le_key   = (r_rx <= r_kx);
    assign o_stat.x_le_smp   = (r_rx <= r_smp);
    assign o_stat.mul_done   = mul_done;
    assign o_stat.div_done   = div_done;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_out_y_min    = r_out_ylo;
    assign o_out_y_max    = r_out_yhi;
    assign o_keys_held    = r_out_cnt;
    assign o_status       = r_out_status;

endmodule

### src/kci_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_ctrl: controller of the keyed curve interpolator
// Sequences the scans, shifts, multiplies and divides of each request.
// ----------------------------------------------------------------------------
module kci_ctrl import kci_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_INS_RD  = 5'd2;
    localparam logic [4:0] S_INS_CHK = 5'd3;
    localparam logic [4:0] S_SH_RD   = 5'd4;
    localparam logic [4:0] S_SH_WR   = 5'd5;
    localparam logic [4:0] S_Y_RD    = 5'd6;
    localparam logic [4:0] S_Y_ACC   = 5'd7;
    localparam logic [4:0] S_EV_RD   = 5'd8;
    localparam logic [4:0] S_EV_CHK  = 5'd9;
    localparam logic [4:0] S_EV_DIV  = 5'd10;
    localparam logic [4:0] S_EV_DIVW = 5'd11;
    localparam logic [4:0] S_EV_MY   = 5'd12;
    localparam logic [4:0] S_EV_MYW  = 5'd13;
    localparam logic [4:0] S_EV_MS   = 5'd14;
    localparam logic [4:0] S_EV_MSW  = 5'd15;
    localparam logic [4:0] S_EV_MR   = 5'd16;
    localparam logic [4:0] S_EV_MRW  = 5'd17;
    localparam logic [4:0] S_RS_RD   = 5'd18;
    localparam logic [4:0] S_RS_MUL  = 5'd19;
    localparam logic [4:0] S_RS_MULW = 5'd20;
    localparam logic [4:0] S_RS_DIV  = 5'd21;
    localparam logic [4:0] S_RS_DIVW = 5'd22;
    localparam logic [4:0] S_DONE    = 5'd23;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.action)
                    ACT_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        n_state = S_DONE;
                    end
                    ACT_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.status_set  = 1'b1;
                            o_cmd.status_code = STAT_FULL;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state = S_INS_RD;
                        end
                    end
                    ACT_EVAL: begin
                        if (i_stat.cnt_zero) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state = S_EV_RD;
                        end
                    end
                    default: begin
                        if (i_stat.span_zero) begin
                            o_cmd.status_set  = 1'b1;
                            o_cmd.status_code = STAT_SPAN;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state = S_RS_RD;
                        end
                    end
                endcase
            end
            S_INS_RD: n_state = S_INS_CHK;
            S_INS_CHK: begin
                // The new key goes after every key whose x is not above it.
                if (!i_stat.idx_at_cnt && i_stat.x_le_key) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    o_cmd.pos_save     = 1'b1;
                    o_cmd.idx_load_cnt = 1'b1;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (i_stat.idx_at_pos) begin
                    o_cmd.wr_new  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.y_init  = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_Y_RD;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_dec  = 1'b1;
                n_state = S_SH_RD;
            end
            S_Y_RD: begin
                if (i_stat.idx_at_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_Y_ACC;
                end
            end
            S_Y_ACC: begin
                o_cmd.y_acc   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_Y_RD;
            end
            S_EV_RD: n_state = S_EV_CHK;
            S_EV_CHK: begin
                priority if (i_stat.idx_at_cnt) begin
                    o_cmd.sel_prev = 1'b1;
                    n_state = S_EV_MR;
                end else if (i_stat.x_le_smp) begin
                    o_cmd.prev_save = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    n_state = S_EV_RD;
                end else if (i_stat.idx_zero) begin
                    o_cmd.sel_cur = 1'b1;
                    n_state = S_EV_MR;
                end else begin
                    o_cmd.cur_save = 1'b1;
                    n_state = S_EV_DIV;
                end
            end
            S_EV_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_T;
                n_state = S_EV_DIVW;
            end
            S_EV_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.t_save = 1'b1;
                    n_state = S_EV_MY;
                end
            end
            S_EV_MY: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_Y;
                n_state = S_EV_MYW;
            end
            S_EV_MYW: begin
                if (i_stat.mul_done) begin
                    o_cmd.y_save = 1'b1;
                    n_state = S_EV_MS;
                end
            end
            S_EV_MS: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_S;
                n_state = S_EV_MSW;
            end
            S_EV_MSW: begin
                if (i_stat.mul_done) begin
                    o_cmd.s_save = 1'b1;
                    n_state = S_EV_MR;
                end
            end
            S_EV_MR: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_RND;
                n_state = S_EV_MRW;
            end
            S_EV_MRW: begin
                if (i_stat.mul_done) begin
                    o_cmd.value_save = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RS_RD: begin
                if (i_stat.idx_at_cnt) begin
                    o_cmd.range_commit = 1'b1;
                    o_cmd.y_init       = 1'b1;
                    o_cmd.idx_clr      = 1'b1;
                    n_state = S_Y_RD;
                end else begin
                    n_state = S_RS_MUL;
                end
            end
            S_RS_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_RS;
                n_state = S_RS_MULW;
            end
            S_RS_MULW: begin
                if (i_stat.mul_done) begin
                    n_state = S_RS_DIV;
                end
            end
            S_RS_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_RS;
                n_state = S_RS_DIVW;
            end
            S_RS_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_rescale = 1'b1;
                    o_cmd.idx_inc    = 1'b1;
                    n_state = S_RS_RD;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### src/keyed_curve_interpolator.sv
`timescale 1ns / 1ps
// An evaluation between two keys uses one 66-bit divide and three 33-bit multiplies;
// a rescale uses a bit-serial multiply and divide on the shared units for each key
// held. One request at a time; the next is taken the cycle after the result is
// loaded. Results are registered.
// Reset (synchronous, active low) empties the table, sets the x range to 0..10.
// ----------------------------------------------------------------------------
// keyed_curve_interpolator: top level
// Sorted key table with linear interpolation, randomised spread and rescaling.
// ----------------------------------------------------------------------------
module keyed_curve_interpolator import kci_pkg::*; #(
    parameter int MAX_KEYS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kci_in_if.sink     i_req,
    kci_out_if.source  o_res
);
    t_cmd  cmd;
    t_stat st;
    logic  in_ready;

    kci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (st),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_req.ready = in_ready;

    kci_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_req.action),
        .i_key_x        (i_req.key_x),
        .i_key_y        (i_req.key_y),
        .i_key_spread   (i_req.key_spread),
        .i_sample_pos   (i_req.sample_pos),
        .i_random_unit  (i_req.random_unit),
        .i_range_min    (i_req.range_min),
        .i_range_max    (i_req.range_max),
        .i_out_ready    (o_res.ready),
        .o_stat         (st),
        .o_out_valid    (o_res.valid),
        .o_sample_value (o_res.sample_value),
        .o_out_y_min    (o_res.out_y_min),
        .o_out_y_max    (o_res.out_y_max),
        .o_keys_held    (o_res.keys_held),
        .o_status       (o_res.status)
    );

`ifndef SYNTHESIS
    // A request is worked on alone: no second request straight after the first.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    // A result is only loaded when the result register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !st.out_busy)
        else $error("result register overwritten while held");

    // The shared arithmetic units are never started together.
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mul_start && cmd.div_start))
        else $error("multiplier and divider started together");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.status == STAT_OK || o_res.status == STAT_FULL ||
                         o_res.status == STAT_SPAN))
        else $error("undefined status code");
`endif

endmodule
